FILE: design/fsc_pkg.sv
// Package for the single-precision sine and cosine unit.
// Holds the floating-point constants, the quadrant tag type and a shared helper function.
// No dependencies.
package fsc_pkg;

   localparam logic [31:0] TWO_OVER_PI = 32'h3F22F983;
   localparam logic [31:0] HALF_PI_HI  = 32'h3FC90FDB;
   localparam logic [31:0] HALF_PI_LO  = 32'hB33BBD2E;
   localparam logic [31:0] POS_HALF    = 32'h3F000000;
   localparam logic [31:0] NEG_HALF    = 32'hBF000000;
   localparam logic [31:0] POS_ONE     = 32'h3F800000;
   localparam logic [31:0] NEG_ZERO    = 32'h80000000;
   localparam logic [31:0] SIN_C3      = 32'hBE2AAAAB;
   localparam logic [31:0] SIN_C5      = 32'h3C088889;
   localparam logic [31:0] SIN_C7      = 32'hB9500D01;
   localparam logic [31:0] SIN_C9      = 32'h3638EF1D;
   localparam logic [31:0] COS_C2      = 32'hBF000000;
   localparam logic [31:0] COS_C4      = 32'h3D2AAAAB;
   localparam logic [31:0] COS_C6      = 32'hBAB60B61;
   localparam logic [31:0] COS_C8      = 32'h37D00D01;
   localparam logic [31:0] COS_C10     = 32'h3493F27E;
   localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
   localparam logic [31:0] QUIET_BIT   = 32'h00400000;
   localparam logic [31:0] SAT_POS_K   = 32'h4F000000;
   localparam logic [31:0] SAT_NEG_K   = 32'hCF000000;

   typedef struct packed {
      logic zero;
      logic neg;
      logic cos;
   } tag_type;

   // Number of leading zeros of a 48-bit word; 48 when the word is zero.
   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            n = 6'(47 - i);
         end
      end
      return n;
   endfunction

endpackage

FILE: design/fsc_if.sv
// Request and response channel interfaces of the sine and cosine unit.
// Independent of the package.
interface fsc_req_if;
   logic        valid;
   logic        ready;
   logic        func_select;
   logic [31:0] angle_bits;

   modport source (output valid, output func_select, output angle_bits, input ready);
   modport sink (input valid, input func_select, input angle_bits, output ready);
endinterface

interface fsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value_bits;

   modport source (output valid, output value_bits, input ready);
   modport sink (input valid, input value_bits, output ready);
endinterface

FILE: design/fsc_fmul.sv
// Three-stage single-precision multiplier, round to nearest even, with subnormals.
// Carries a side word and a valid bit alongside the product. Uses fsc_pkg.
module fsc_fmul #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [31:0]       a,
   input  logic [31:0]       b,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [31:0]       y,
   output logic [SIDE_W-1:0] side_out
);

   logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn_in;
   logic [23:0] ma, mb;
   logic [7:0] eae, ebe;
   logic [47:0] prod_in;
   logic signed [10:0] ez_in;
   logic spec_in;
   logic [31:0] specv_in;

   logic v1_ff, sgn1_ff, spec1_ff;
   logic [47:0] prod_ff;
   logic signed [10:0] ez_ff;
   logic [31:0] specv1_ff;
   logic [SIDE_W-1:0] side1_ff;

   assign a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   assign b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   assign a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
   assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
   assign a_zero = (a[30:0] == 31'd0);
   assign b_zero = (b[30:0] == 31'd0);
   assign sgn_in = a[31] ^ b[31];
   assign ma     = {a[30:23] != 8'd0, a[22:0]};
   assign mb     = {b[30:23] != 8'd0, b[22:0]};
   assign eae    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
   assign ebe    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
   assign prod_in = 48'(ma) * 48'(mb);
   assign ez_in  = $signed({3'b000, eae}) + $signed({3'b000, ebe}) - 11'sd126;

   always_comb begin
      spec_in  = 1'b1;
      specv_in = '0;
      if (a_nan) begin
         specv_in = a | fsc_pkg::QUIET_BIT;
      end else if (b_nan) begin
         specv_in = b | fsc_pkg::QUIET_BIT;
      end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
         specv_in = fsc_pkg::DEFAULT_NAN;
      end else if (a_inf || b_inf) begin
         specv_in = {sgn_in, 8'hFF, 23'd0};
      end else if (a_zero || b_zero) begin
         specv_in = {sgn_in, 31'd0};
      end else begin
         spec_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         prod_ff   <= prod_in;
         ez_ff     <= ez_in;
         sgn1_ff   <= sgn_in;
         spec1_ff  <= spec_in;
         specv1_ff <= specv_in;
         side1_ff  <= side_in;
      end
   end

   logic [5:0] lz;
   logic signed [10:0] enorm, rtmp;
   logic [5:0] shl;
   logic [6:0] rsh;
   logic rmode, ovf_in;
   logic [7:0] ef_in;
   logic [95:0] wide;
   logic [47:0] pre;
   logic [23:0] mant_in;
   logic g_in, st_in;

   logic v2_ff, sgn2_ff, spec2_ff, ovf_ff, g_ff, st_ff;
   logic [23:0] mant_ff;
   logic [7:0] ef_ff;
   logic [31:0] specv2_ff;
   logic [SIDE_W-1:0] side2_ff;

   assign lz    = fsc_pkg::lzc48(prod_ff);
   assign enorm = ez_ff - $signed({5'b00000, lz});
   assign rtmp  = 11'sd1 - ez_ff;

   always_comb begin
      shl    = '0;
      rsh    = '0;
      rmode  = 1'b0;
      ovf_in = 1'b0;
      ef_in  = '0;
      if (enorm >= 11'sd1) begin
         shl    = lz;
         ovf_in = (enorm >= 11'sd255);
         ef_in  = enorm[7:0];
      end else if (ez_ff >= 11'sd1) begin
         shl = 6'(ez_ff - 11'sd1);
      end else begin
         rmode = 1'b1;
         rsh   = (rtmp > 11'sd49) ? 7'd49 : 7'(rtmp);
      end
   end

   assign wide    = {prod_ff, 48'd0} >> rsh;
   assign pre     = rmode ? wide[95:48] : (prod_ff << shl);
   assign mant_in = pre[47:24];
   assign g_in    = pre[23];
   assign st_in   = (|pre[22:0]) | (rmode & (|wide[47:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         mant_ff   <= mant_in;
         g_ff      <= g_in;
         st_ff     <= st_in;
         ef_ff     <= ef_in;
         ovf_ff    <= ovf_in;
         sgn2_ff   <= sgn1_ff;
         spec2_ff  <= spec1_ff;
         specv2_ff <= specv1_ff;
         side2_ff  <= side1_ff;
      end
   end

   logic up;
   logic [30:0] packed_mag;
   logic [31:0] y_in;
   logic v3_ff;
   logic [31:0] y_ff;
   logic [SIDE_W-1:0] side3_ff;

   assign up         = g_ff & (st_ff | mant_ff[0]);
   assign packed_mag = {ef_ff, mant_ff[22:0]} + 31'(up);

   always_comb begin
      if (spec2_ff) begin
         y_in = specv2_ff;
      end else if (ovf_ff) begin
         y_in = {sgn2_ff, 8'hFF, 23'd0};
      end else begin
         y_in = {sgn2_ff, packed_mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         y_ff     <= y_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign y         = y_ff;
   assign side_out  = side3_ff;

endmodule

FILE: design/fsc_fadd.sv
// Three-stage single-precision adder, round to nearest even, with subnormals.
// Carries a side word and a valid bit alongside the sum. Uses fsc_pkg.
module fsc_fadd #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [31:0]       a,
   input  logic [31:0]       b,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [31:0]       y,
   output logic [SIDE_W-1:0] side_out
);

   logic a_nan, b_nan, a_inf, b_inf, swap;
   logic [31:0] big, sml;
   logic [7:0] e1_in, e2;
   logic [7:0] dexp;
   logic [4:0] dc;
   logic [26:0] m1x_in, m2x;
   logic [53:0] al;
   logic [26:0] m2a_in;
   logic spec_in;
   logic [31:0] specv_in;

   logic v1_ff, s1_ff, sub1_ff, spec1_ff;
   logic [26:0] m1x_ff, m2a_ff;
   logic [7:0] e1_ff;
   logic [31:0] specv1_ff;
   logic [SIDE_W-1:0] side1_ff;

   assign a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   assign b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   assign a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
   assign b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
   assign swap  = (b[30:0] > a[30:0]);
   assign big   = swap ? b : a;
   assign sml   = swap ? a : b;
   assign e1_in = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
   assign e2    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
   assign dexp  = e1_in - e2;
   assign dc    = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
   assign m1x_in = {big[30:23] != 8'd0, big[22:0], 3'b000};
   assign m2x   = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
   assign al    = {m2x, 27'd0} >> dc;
   assign m2a_in = {al[53:28], al[27] | (|al[26:0])};

   always_comb begin
      spec_in  = 1'b1;
      specv_in = '0;
      if (a_nan) begin
         specv_in = a | fsc_pkg::QUIET_BIT;
      end else if (b_nan) begin
         specv_in = b | fsc_pkg::QUIET_BIT;
      end else if (a_inf && b_inf && (a[31] != b[31])) begin
         specv_in = fsc_pkg::DEFAULT_NAN;
      end else if (a_inf) begin
         specv_in = a;
      end else if (b_inf) begin
         specv_in = b;
      end else begin
         spec_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         m1x_ff    <= m1x_in;
         m2a_ff    <= m2a_in;
         e1_ff     <= e1_in;
         s1_ff     <= big[31];
         sub1_ff   <= a[31] ^ b[31];
         spec1_ff  <= spec_in;
         specv1_ff <= specv_in;
         side1_ff  <= side_in;
      end
   end

   logic [27:0] sum_in;
   logic [5:0] lz_in;

   logic v2_ff, s2_ff, sub2_ff, spec2_ff;
   logic [27:0] sum_ff;
   logic [5:0] lz_ff;
   logic [7:0] e2_ff;
   logic [31:0] specv2_ff;
   logic [SIDE_W-1:0] side2_ff;

   assign sum_in = sub1_ff ? ({1'b0, m1x_ff} - {1'b0, m2a_ff})
                           : ({1'b0, m1x_ff} + {1'b0, m2a_ff});
   assign lz_in  = fsc_pkg::lzc48({sum_in, 20'd0});

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         sum_ff    <= sum_in;
         lz_ff     <= lz_in;
         e2_ff     <= e1_ff;
         s2_ff     <= s1_ff;
         sub2_ff   <= sub1_ff;
         spec2_ff  <= spec1_ff;
         specv2_ff <= specv1_ff;
         side2_ff  <= side1_ff;
      end
   end

   logic [4:0] want, sh;
   logic [7:0] lim;
   logic [26:0] nrm;
   logic [8:0] ef;
   logic up;
   logic [30:0] packed_mag;
   logic [31:0] y_in;
   logic v3_ff;
   logic [31:0] y_ff;
   logic [SIDE_W-1:0] side3_ff;

   assign want = 5'(lz_ff - 6'd1);
   assign lim  = e2_ff - 8'd1;

   always_comb begin
      sh  = '0;
      nrm = '0;
      ef  = '0;
      if (sum_ff[27]) begin
         nrm = {sum_ff[27:2], sum_ff[1] | sum_ff[0]};
         ef  = {1'b0, e2_ff} + 9'd1;
      end else begin
         if ({3'b000, want} <= lim) begin
            sh = want;
            ef = {1'b0, e2_ff} - {4'd0, want};
         end else begin
            sh = lim[4:0];
         end
         nrm = sum_ff[26:0] << sh;
      end
   end

   assign up         = nrm[2] & ((|nrm[1:0]) | nrm[3]);
   assign packed_mag = {ef[7:0], nrm[25:3]} + 31'(up);

   always_comb begin
      if (spec2_ff) begin
         y_in = specv2_ff;
      end else if (sum_ff == 28'd0) begin
         y_in = {s2_ff & ~sub2_ff, 31'd0};
      end else if (ef >= 9'd255) begin
         y_in = {s2_ff, 8'hFF, 23'd0};
      end else begin
         y_in = {s2_ff, packed_mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         y_ff     <= y_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign y         = y_ff;
   assign side_out  = side3_ff;

endmodule

FILE: design/float_sine_cosine_unit_core.sv
// One request accepted per cycle whenever the pipeline advances.
// Seventeen three-stage floating-point units, one quadrant stage and the result register
// form a single pipeline that advances whenever the result register is free or being taken.
// Synchronous reset clears every valid bit; data registers are not reset.
// Uses fsc_pkg, fsc_req_if, fsc_rsp_if, fsc_fmul and fsc_fadd.
module float_sine_cosine_unit_core (
   input logic      clock,
   input logic      reset,
   fsc_req_if.sink  req_ch,
   fsc_rsp_if.source rsp_ch
);

   logic en;
   logic rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic [31:0] rsp_value_in;

   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // Scale by 2/pi and round half away from zero.
   logic v1; logic [31:0] y1; logic [32:0] sd1;
   fsc_fmul #(.SIDE_W(33)) u_scale (
      .clock, .reset, .en, .in_valid(req_ch.valid), .a(req_ch.angle_bits),
      .b(fsc_pkg::TWO_OVER_PI), .side_in({req_ch.func_select, req_ch.angle_bits}),
      .out_valid(v1), .y(y1), .side_out(sd1));

   logic [31:0] half;
   assign half = (y1[31] && (y1[30:0] != 31'd0)) ? fsc_pkg::NEG_HALF : fsc_pkg::POS_HALF;

   logic v2; logic [31:0] y2; logic [32:0] sd2;
   fsc_fadd #(.SIDE_W(33)) u_round (
      .clock, .reset, .en, .in_valid(v1), .a(y1), .b(half), .side_in(sd1),
      .out_valid(v2), .y(y2), .side_out(sd2));

   // Quadrant count: truncate, saturate, take the low two bits.
   logic [7:0] et;
   logic [4:0] ei, fsh;
   logic [53:0] ishift;
   logic [22:0] fmask;
   logic [1:0] low2, kq;
   logic [31:0] kf_in;
   logic [1:0] selq;
   fsc_pkg::tag_type tag_in;

   assign et     = y2[30:23];
   assign ei     = 5'(et - 8'd127);
   assign fsh    = (ei >= 5'd23) ? 5'd0 : 5'(5'd23 - ei);
   assign fmask  = 23'h7FFFFF << fsh;
   assign ishift = {30'd0, 1'b1, y2[22:0]} << ei;
   assign low2   = ishift[24:23];

   always_comb begin
      if (et >= 8'd158) begin
         kq    = y2[31] ? 2'd0 : 2'd3;
         kf_in = y2[31] ? fsc_pkg::SAT_NEG_K : fsc_pkg::SAT_POS_K;
      end else if (et < 8'd127) begin
         kq    = 2'd0;
         kf_in = '0;
      end else begin
         kq    = y2[31] ? 2'(2'd0 - low2) : low2;
         kf_in = {y2[31], et, y2[22:0] & fmask};
      end
   end

   assign selq        = kq + {1'b0, sd2[32]};
   assign tag_in.zero = (sd2[30:23] == 8'hFF);
   assign tag_in.neg  = selq[1];
   assign tag_in.cos  = selq[0];

   logic vq_ff;
   fsc_pkg::tag_type tagq_ff;
   logic [31:0] kf_ff, xq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff <= 1'b0;
      end else if (en) begin
         vq_ff <= v2;
      end
      if (en) begin
         tagq_ff <= tag_in;
         kf_ff   <= kf_in;
         xq_ff   <= sd2[31:0];
      end
   end

   // Cody-Waite reduction.
   logic v3; logic [31:0] y3; logic [66:0] sd3;
   fsc_pkg::tag_type tag3; logic [31:0] x3, kf3;
   fsc_fmul #(.SIDE_W(67)) u_phi (
      .clock, .reset, .en, .in_valid(vq_ff), .a(kf_ff), .b(fsc_pkg::HALF_PI_HI),
      .side_in({tagq_ff, xq_ff, kf_ff}), .out_valid(v3), .y(y3), .side_out(sd3));
   assign {tag3, x3, kf3} = sd3;

   logic v4; logic [31:0] y4; logic [34:0] sd4;
   fsc_pkg::tag_type tag4; logic [31:0] kf4;
   fsc_fadd #(.SIDE_W(35)) u_dsub (
      .clock, .reset, .en, .in_valid(v3), .a(x3), .b({~y3[31], y3[30:0]}),
      .side_in({tag3, kf3}), .out_valid(v4), .y(y4), .side_out(sd4));
   assign {tag4, kf4} = sd4;

   logic v5; logic [31:0] y5; logic [34:0] sd5;
   fsc_pkg::tag_type tag5; logic [31:0] d5;
   fsc_fmul #(.SIDE_W(35)) u_plo (
      .clock, .reset, .en, .in_valid(v4), .a(kf4), .b(fsc_pkg::HALF_PI_LO),
      .side_in({tag4, y4}), .out_valid(v5), .y(y5), .side_out(sd5));
   assign {tag5, d5} = sd5;

   logic v6; logic [31:0] y6; fsc_pkg::tag_type tag6;
   fsc_fadd #(.SIDE_W(3)) u_rsub (
      .clock, .reset, .en, .in_valid(v5), .a(d5), .b({~y5[31], y5[30:0]}),
      .side_in(tag5), .out_valid(v6), .y(y6), .side_out(tag6));

   // Polynomial kernel.
   logic v7; logic [31:0] y7; logic [34:0] sd7;
   fsc_pkg::tag_type tag7; logic [31:0] r7;
   fsc_fmul #(.SIDE_W(35)) u_sq (
      .clock, .reset, .en, .in_valid(v6), .a(y6), .b(y6),
      .side_in({tag6, y6}), .out_valid(v7), .y(y7), .side_out(sd7));
   assign {tag7, r7} = sd7;

   logic v8; logic [31:0] y8; logic [66:0] sd8;
   fsc_pkg::tag_type tag8; logic [31:0] r8, q8;
   fsc_fmul #(.SIDE_W(67)) u_m0 (
      .clock, .reset, .en, .in_valid(v7), .a(y7),
      .b(tag7.cos ? fsc_pkg::COS_C10 : fsc_pkg::SIN_C9),
      .side_in({tag7, r7, y7}), .out_valid(v8), .y(y8), .side_out(sd8));
   assign {tag8, r8, q8} = sd8;

   logic v9; logic [31:0] y9; logic [66:0] sd9;
   fsc_pkg::tag_type tag9; logic [31:0] r9, q9;
   fsc_fadd #(.SIDE_W(67)) u_a1 (
      .clock, .reset, .en, .in_valid(v8),
      .a(tag8.cos ? fsc_pkg::COS_C8 : fsc_pkg::SIN_C7),
      .b({y8[31] ^ tag8.cos, y8[30:0]}),
      .side_in(sd8), .out_valid(v9), .y(y9), .side_out(sd9));
   assign {tag9, r9, q9} = sd9;

   logic v10; logic [31:0] y10; logic [66:0] sd10;
   fsc_pkg::tag_type tag10; logic [31:0] r10, q10;
   fsc_fmul #(.SIDE_W(67)) u_m1 (
      .clock, .reset, .en, .in_valid(v9), .a(q9), .b(y9),
      .side_in(sd9), .out_valid(v10), .y(y10), .side_out(sd10));
   assign {tag10, r10, q10} = sd10;

   logic v11; logic [31:0] y11; logic [66:0] sd11;
   fsc_pkg::tag_type tag11; logic [31:0] r11, q11;
   fsc_fadd #(.SIDE_W(67)) u_a2 (
      .clock, .reset, .en, .in_valid(v10),
      .a(tag10.cos ? fsc_pkg::COS_C6 : fsc_pkg::SIN_C5), .b(y10),
      .side_in(sd10), .out_valid(v11), .y(y11), .side_out(sd11));
   assign {tag11, r11, q11} = sd11;

   logic v12; logic [31:0] y12; logic [66:0] sd12;
   fsc_pkg::tag_type tag12; logic [31:0] r12, q12;
   fsc_fmul #(.SIDE_W(67)) u_m2 (
      .clock, .reset, .en, .in_valid(v11), .a(q11), .b(y11),
      .side_in(sd11), .out_valid(v12), .y(y12), .side_out(sd12));
   assign {tag12, r12, q12} = sd12;

   logic v13; logic [31:0] y13; logic [66:0] sd13;
   fsc_pkg::tag_type tag13; logic [31:0] r13, q13;
   fsc_fadd #(.SIDE_W(67)) u_a3 (
      .clock, .reset, .en, .in_valid(v12),
      .a(tag12.cos ? fsc_pkg::COS_C4 : fsc_pkg::SIN_C3), .b(y12),
      .side_in(sd12), .out_valid(v13), .y(y13), .side_out(sd13));
   assign {tag13, r13, q13} = sd13;

   logic v14; logic [31:0] y14; logic [66:0] sd14;
   fsc_pkg::tag_type tag14; logic [31:0] r14, q14;
   fsc_fmul #(.SIDE_W(67)) u_m3 (
      .clock, .reset, .en, .in_valid(v13), .a(q13), .b(y13),
      .side_in(sd13), .out_valid(v14), .y(y14), .side_out(sd14));
   assign {tag14, r14, q14} = sd14;

   logic v15; logic [31:0] y15; logic [66:0] sd15;
   fsc_pkg::tag_type tag15; logic [31:0] r15, q15;
   fsc_fadd #(.SIDE_W(67)) u_a4 (
      .clock, .reset, .en, .in_valid(v14),
      .a(tag14.cos ? fsc_pkg::COS_C2 : fsc_pkg::POS_ONE), .b(y14),
      .side_in(sd14), .out_valid(v15), .y(y15), .side_out(sd15));
   assign {tag15, r15, q15} = sd15;

   logic v16; logic [31:0] y16; fsc_pkg::tag_type tag16;
   fsc_fmul #(.SIDE_W(3)) u_m4 (
      .clock, .reset, .en, .in_valid(v15), .a(tag15.cos ? q15 : r15), .b(y15),
      .side_in(tag15), .out_valid(v16), .y(y16), .side_out(tag16));

   // Sine passes through an addition of negative zero, which leaves it unchanged.
   logic v17; logic [31:0] y17; fsc_pkg::tag_type tag17;
   fsc_fadd #(.SIDE_W(3)) u_a5 (
      .clock, .reset, .en, .in_valid(v16), .a(y16),
      .b(tag16.cos ? fsc_pkg::POS_ONE : fsc_pkg::NEG_ZERO),
      .side_in(tag16), .out_valid(v17), .y(y17), .side_out(tag17));

   assign rsp_value_in = tag17.zero ? 32'd0 : {y17[31] ^ tag17.neg, y17[30:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v17;
      end
      if (en) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.value_bits = rsp_value_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v17) && $stable(y17) && $stable(v1))
      else $error("pipeline moved while stalled");

   a_nonfinite_zero: assert property (@(posedge clock) disable iff (reset)
      (en && v17 && tag17.zero) |=> (rsp_valid_ff && (rsp_value_ff == 32'd0)))
      else $error("non-finite angle did not give zero");

endmodule

FILE: tb/float_sine_cosine_unit_core_test.sv
// Self-checking testbench for the single-precision sine and cosine unit core.
// Each result is checked bit for bit against a predictor built from integer IEEE add and multiply.
// Depends on fsc_pkg, fsc_req_if, fsc_rsp_if and float_sine_cosine_unit_core.
`timescale 1ns / 1ps

module float_sine_cosine_unit_core_test;

   logic clock;
   logic reset;

   fsc_req_if req_ch ();
   fsc_rsp_if rsp_ch ();

   float_sine_cosine_unit_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [31:0] expected_values[$];
   int          mismatch_count;
   int          burst_left;
   bit          no_gaps;
   int          hold_cycles;
   int          stall_percent;
   int          stall_phase;

   always #10 clock = ~clock;

   // Rounds m * 2^e to single precision, nearest even, with gradual underflow.
   function automatic logic [31:0] round_pack(input logic sgn, input int e,
                                               input logic [63:0] m);
      int          p;
      int          ee;
      int          sh;
      logic [63:0] q;
      logic        rb;
      logic        st;
      if (m == 0) begin
         return {sgn, 31'b0};
      end
      p = 63;
      while (!m[p]) begin
         p--;
      end
      ee = p + e;
      if (ee < -126) begin
         ee = -126;
      end
      sh = (ee - 23) - e;
      if (sh > 0) begin
         if (sh > 64) begin
            q = 0; rb = 0; st = 1;
         end else if (sh == 64) begin
            q = 0; rb = m[63]; st = |(m << 1);
         end else begin
            q  = m >> sh;
            rb = m[sh-1];
            st = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
         end
         if (rb && (st || q[0])) begin
            q++;
         end
      end else begin
         q = m << (-sh);
      end
      if (q[24]) begin
         q >>= 1;
         ee++;
      end
      if (ee + 127 >= 255) begin
         return {sgn, 8'hFF, 23'b0};
      end
      return {sgn, q[23] ? 8'(ee + 127) : 8'd0, q[22:0]};
   endfunction

   function automatic logic [23:0] significand(input logic [31:0] a);
      return {a[30:23] != 0, a[22:0]};
   endfunction

   function automatic int exponent_of(input logic [31:0] a);
      return (a[30:23] == 0) ? -126 : int'(a[30:23]) - 127;
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic [23:0] ma;
      logic [23:0] mb;
      ma = significand(a);
      mb = significand(b);
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
         if (a[30:0] == 0 || b[30:0] == 0) begin
            return fsc_pkg::DEFAULT_NAN;
         end
         return {a[31] ^ b[31], 8'hFF, 23'b0};
      end
      if (ma == 0 || mb == 0) begin
         return {a[31] ^ b[31], 31'b0};
      end
      return round_pack(a[31] ^ b[31], exponent_of(a) + exponent_of(b) - 46,
                        64'(ma) * 64'(mb));
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] x;
      logic [31:0] y;
      logic [63:0] big;
      logic [63:0] sml;
      logic [63:0] shifted;
      logic [63:0] m;
      logic        sgn;
      int          d;
      if (a[30:23] == 8'hFF) begin
         if (b[30:23] == 8'hFF && a[31] != b[31]) begin
            return fsc_pkg::DEFAULT_NAN;
         end
         return a;
      end
      if (b[30:23] == 8'hFF) begin
         return b;
      end
      if (significand(a) == 0 && significand(b) == 0) begin
         return {a[31] & b[31], 31'b0};
      end
      if (significand(a) == 0) begin
         return b;
      end
      if (significand(b) == 0) begin
         return a;
      end
      if (exponent_of(a) >= exponent_of(b)) begin
         x = a; y = b;
      end else begin
         x = b; y = a;
      end
      d       = exponent_of(x) - exponent_of(y);
      big     = 64'(significand(x)) << 30;
      shifted = 64'(significand(y)) << 30;
      if (d >= 54) begin
         sml = 64'd1;
      end else begin
         sml = shifted >> d;
         if ((sml << d) != shifted) begin
            sml |= 64'd1;
         end
      end
      if (x[31] == y[31]) begin
         m = big + sml; sgn = x[31];
      end else if (big >= sml) begin
         m = big - sml; sgn = x[31];
      end else begin
         m = sml - big; sgn = y[31];
      end
      if (m == 0) begin
         return 32'h0;
      end
      return round_pack(sgn, exponent_of(x) - 53, m);
   endfunction

   function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
      return fp_add(a, {~b[31], b[30:0]});
   endfunction

   function automatic logic [31:0] sine_series(input logic [31:0] r);
      logic [31:0] r2;
      logic [31:0] acc;
      r2  = fp_mul(r, r);
      acc = fp_mul(r2, fsc_pkg::SIN_C9);
      acc = fp_add(fsc_pkg::SIN_C7, acc);
      acc = fp_mul(r2, acc);
      acc = fp_add(fsc_pkg::SIN_C5, acc);
      acc = fp_mul(r2, acc);
      acc = fp_add(fsc_pkg::SIN_C3, acc);
      acc = fp_mul(r2, acc);
      acc = fp_add(fsc_pkg::POS_ONE, acc);
      return fp_mul(r, acc);
   endfunction

   function automatic logic [31:0] cosine_series(input logic [31:0] r);
      logic [31:0] r2;
      logic [31:0] acc;
      r2  = fp_mul(r, r);
      acc = fp_mul(r2, fsc_pkg::COS_C10);
      acc = fp_sub(fsc_pkg::COS_C8, acc);
      acc = fp_mul(r2, acc);
      acc = fp_add(fsc_pkg::COS_C6, acc);
      acc = fp_mul(r2, acc);
      acc = fp_add(fsc_pkg::COS_C4, acc);
      acc = fp_mul(r2, acc);
      acc = fp_add(fsc_pkg::COS_C2, acc);
      acc = fp_mul(r2, acc);
      return fp_add(fsc_pkg::POS_ONE, acc);
   endfunction

   function automatic logic [31:0] predict_sine_cosine(input logic sel, input logic [31:0] x);
      logic [31:0] s;
      logic [31:0] t;
      logic [31:0] kf;
      logic [31:0] r;
      logic [31:0] v;
      logic [1:0]  kq;
      logic [31:0] mag;
      int          e;
      if (x[30:23] == 8'hFF) begin
         return 32'h0;
      end
      s = fp_mul(x, fsc_pkg::TWO_OVER_PI);
      if (!s[31] || s[30:0] == 0) begin
         t = fp_add(s, fsc_pkg::POS_HALF);
      end else begin
         t = fp_sub(s, fsc_pkg::POS_HALF);
      end
      if (!t[31] && {1'b0, t[30:0]} >= fsc_pkg::SAT_POS_K) begin
         kq = 2'd3; kf = fsc_pkg::SAT_POS_K;
      end else if (t[31] &&
                   {1'b0, t[30:0]} > (fsc_pkg::SAT_NEG_K & ~fsc_pkg::NEG_ZERO)) begin
         kq = 2'd0; kf = fsc_pkg::SAT_NEG_K;
      end else if (t[30:23] < 8'd127) begin
         kq = 2'd0; kf = 32'h0;
      end else begin
         e = int'(t[30:23]) - 127;
         if (e >= 23) begin
            kf  = t;
            mag = 32'(significand(t)) << (e - 23);
         end else begin
            kf  = {t[31:23], t[22:0] & ~((23'd1 << (23 - e)) - 23'd1)};
            mag = 32'(significand(t)) >> (23 - e);
         end
         kq = t[31] ? 2'(-mag) : mag[1:0];
      end
      r = fp_sub(fp_sub(x, fp_mul(kf, fsc_pkg::HALF_PI_HI)),
                 fp_mul(kf, fsc_pkg::HALF_PI_LO));
      case (2'(kq + sel))
         2'd0: begin
            v = sine_series(r);
         end
         2'd1: begin
            v = cosine_series(r);
         end
         2'd2: begin
            v = sine_series(r) ^ fsc_pkg::NEG_ZERO;
         end
         default: begin
            v = cosine_series(r) ^ fsc_pkg::NEG_ZERO;
         end
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s: got %08h, expected %08h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Sends one request; requests go in bursts separated by random gaps unless no_gaps is set.
   task automatic send_request(input logic sel, input logic [31:0] angle);
      if (burst_left == 0 && !no_gaps) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func_select <= sel;
      req_ch.angle_bits  <= angle;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      expected_values.push_back(predict_sine_cosine(sel, angle));
      if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   function automatic logic [31:0] random_angle();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         return {1'($urandom), 8'($urandom_range(110, 134)), 23'($urandom)};
      end else if (pick < 8) begin
         return {1'($urandom), 8'($urandom_range(0, 254)), 23'($urandom)};
      end
      return $urandom;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_values.size() == 0) begin
            report_mismatch("result with none expected", rsp_ch.value_bits, 32'h0);
         end else if (rsp_ch.value_bits !== expected_values[0]) begin
            report_mismatch("value_bits", rsp_ch.value_bits, expected_values.pop_front());
         end else begin
            void'(expected_values.pop_front());
         end
      end
      stall_phase++;
      if (stall_phase >= 64) begin
         stall_phase   = 0;
         stall_percent = $urandom_range(0, 2) * 30;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_percent);
      end
   end

   task automatic test_directed();
      logic [31:0] angles[12];
      angles = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h807FFFFF,
                 32'h3FC90FDB, 32'hC0490FDB, 32'h4F4A0000, 32'hCF4A0000,
                 32'h7F7FFFFF, 32'h7F800000, 32'hFF800000, 32'h7FC00001};
      foreach (angles[i]) begin
         send_request(1'b0, angles[i]);
         send_request(1'b1, angles[i]);
      end
   endtask

   task automatic test_random();
      repeat (900) begin
         send_request(1'($urandom), random_angle());
      end
   endtask

   task automatic test_backpressure();
      no_gaps     = 1'b1;
      hold_cycles = 200;
      repeat (130) begin
         send_request(1'($urandom), random_angle());
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func_select = 1'b0;
      req_ch.angle_bits  = 32'h0;
      rsp_ch.ready       = 1'b0;
      mismatch_count     = 0;
      burst_left         = 0;
      no_gaps            = 1'b0;
      hold_cycles        = 0;
      stall_percent      = 0;
      stall_phase        = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      req_ch.valid <= 1'b0;
      while (expected_values.size() != 0) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_values.size() == 0) begin
         $display("float_sine_cosine_unit_core: match");
      end else begin
         $display("float_sine_cosine_unit_core: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("float_sine_cosine_unit_core: mismatch");
      $finish;
   end

endmodule
